// ----- sv/lpht_pkg.sv -----
// Shared types and constants for the linear probe hash table.
`timescale 1ns / 1ps
package lpht_pkg;

    // Request codes on the command input
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    // Result status codes
    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_CONFLICT = 3'd2,
        ST_INVALID  = 3'd3,
        ST_FULL     = 3'd4,
        ST_HIT      = 3'd5,
        ST_MISS     = 3'd6,
        ST_CLEARED  = 3'd7
    } t_status;

    // Configuration register indexes
    localparam logic [0:0] REG_SIZE_LOG2 = 1'b0;
    localparam logic [0:0] REG_STRICT    = 1'b1;
    localparam int         CFG_W         = 4;
    localparam logic [3:0] SIZE_LOG2_RST = 4'd10;
    localparam logic [4:0] SIZE_LOG2_MIN = 5'd4;

    // Mixer constants
    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
    localparam int          MIX_S0 = 30;
    localparam int          MIX_S1 = 27;
    localparam int          MIX_S2 = 31;

    // Stored word layout: used flag, parent, name, value, extra
    localparam int WORD_W = 1 + 4 * 32;

    // Controller to datapath commands
    typedef struct packed {
        logic    load_req;
        logic    hash_start;
        logic    probe_init;
        logic    probe_next;
        logic    rd_en;
        logic    wr_ins;
        logic    clr_init;
        logic    clr_step;
        logic    res_load;
        t_status res_status;
        logic    res_take_data;
    } t_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic is_insert;
        logic is_lookup;
        logic is_clear;
        logic key_ok;
        logic val_ok;
        logic hash_done;
        logic slot_empty;
        logic key_match;
        logic dup_ok;
        logic probe_last;
        logic clr_last;
    } t_sts;

endpackage

// ----- sv/linear_probe_hash_table.sv -----
// Top level of the linear probe hash table.
`timescale 1ns / 1ps
// Open-addressing table keyed by (parent, name), one result per request.
// A request is taken when start is high and busy is low; its result is on
// the o_result_* ports for one cycle with o_result_valid and cannot be held
// off. Insert and lookup go through decode, then the mixer, which shares
// one 32x32 multiplier over six partial products, then a read and a check
// of the single slot RAM per probe; the result strobe is registered from
// the check of the slot that decides. busy drops with the strobe, so the
// next request can be taken at the edge that ends it. Clear and the pass
// after reset sweep all 2^SLOTS_LOG2 slots one per cycle (clear goes
// through decode first); busy stays high during the sweep. Write
// configuration only while busy is low.
module linear_probe_hash_table #(
    parameter int SLOTS_LOG2 = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [lpht_pkg::CFG_W-1:0] i_cfg_data,
    input  logic [1:0]                 i_cmd,
    input  logic [31:0]                i_key_parent,
    input  logic [31:0]                i_key_name,
    input  logic [31:0]                i_entry_value,
    input  logic [31:0]                i_entry_extra,
    output logic                       o_result_valid,
    output logic [2:0]                 o_result_status,
    output logic [31:0]                o_found_value,
    output logic [31:0]                o_found_extra
);
    lpht_pkg::t_ctl w_ctl;
    lpht_pkg::t_sts w_sts;

    lpht_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sts          (w_sts),
        .o_ctl          (w_ctl),
        .o_result_valid (o_result_valid)
    );

    lpht_dp #(
        .SLOTS_LOG2 (SLOTS_LOG2)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_cmd),
        .i_key_parent    (i_key_parent),
        .i_key_name      (i_key_name),
        .i_entry_value   (i_entry_value),
        .i_entry_extra   (i_entry_extra),
        .o_result_status (o_result_status),
        .o_found_value   (o_found_value),
        .o_found_extra   (o_found_extra)
    );
endmodule

// ----- sv/lpht_ram.sv -----
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/lpht_hash.sv -----
// Multi-cycle 64-bit mixer on one shared 32x32 multiplier.
`timescale 1ns / 1ps
module lpht_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_key,
    output logic        o_done,
    output logic [63:0] o_hash
);
    typedef enum logic [3:0] {
        HS_IDLE,
        HS_M1A,
        HS_M1B,
        HS_M1C,
        HS_MIX,
        HS_M2A,
        HS_M2B,
        HS_M2C,
        HS_DONE
    } t_hstep;

    t_hstep      r_step;
    logic [63:0] r_x;
    logic [63:0] r_acc;
    logic [63:0] w_c;
    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [63:0] w_prod;

    // Partial product operand select: lo*lo, hi*lo, lo*hi
    always_comb begin
        w_c = (r_step < HS_MIX) ? lpht_pkg::MIX_C1 : lpht_pkg::MIX_C2;
        case (r_step)
            HS_M1B, HS_M2B: begin
                w_a = r_x[63:32];
                w_b = w_c[31:0];
            end
            HS_M1C, HS_M2C: begin
                w_a = r_x[31:0];
                w_b = w_c[63:32];
            end
            default: begin
                w_a = r_x[31:0];
                w_b = w_c[31:0];
            end
        endcase
        w_prod = {32'h0, w_a} * {32'h0, w_b};
    end

    // Step sequencer and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= HS_IDLE;
        end else begin
            case (r_step)
                HS_IDLE: begin
                    if (i_start) begin
                        r_step <= HS_M1A;
                    end
                end
                HS_DONE: r_step <= HS_IDLE;
                default: r_step <= t_hstep'(r_step + 4'd1);
            endcase
        end
        case (r_step)
            HS_IDLE: begin
                if (i_start) begin
                    r_x <= i_key ^ (i_key >> lpht_pkg::MIX_S0);
                end
            end
            HS_M1A, HS_M2A: r_acc <= w_prod;
            HS_M1B, HS_M1C, HS_M2B, HS_M2C: r_acc <= r_acc + {w_prod[31:0], 32'h0};
            HS_MIX: r_x <= r_acc ^ (r_acc >> lpht_pkg::MIX_S1);
            default: r_acc <= r_acc;
        endcase
    end

    assign o_done = (r_step == HS_DONE);
    assign o_hash = r_acc ^ (r_acc >> lpht_pkg::MIX_S2);
endmodule

// ----- sv/lpht_dp.sv -----
// Datapath: request registers, config, probe pointer, slot RAM and result.
`timescale 1ns / 1ps
module lpht_dp #(
    parameter int SLOTS_LOG2 = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpht_pkg::t_ctl                i_ctl,
    output lpht_pkg::t_sts                o_sts,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [lpht_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [1:0]                    i_cmd,
    input  logic [31:0]                   i_key_parent,
    input  logic [31:0]                   i_key_name,
    input  logic [31:0]                   i_entry_value,
    input  logic [31:0]                   i_entry_extra,
    output logic [2:0]                    o_result_status,
    output logic [31:0]                   o_found_value,
    output logic [31:0]                   o_found_extra
);
    localparam int AW = SLOTS_LOG2;

    logic [1:0]  r_cmd;
    logic [31:0] r_parent, r_name, r_value, r_extra;
    logic [3:0]  r_size_log2;
    logic        r_strict;
    logic [AW-1:0] r_pos, r_cnt, r_clr;
    logic [2:0]  r_res_status;
    logic [31:0] r_res_value, r_res_extra;

    logic [4:0]  w_act;
    logic [AW-1:0] w_mask;
    logic        w_hdone;
    logic [63:0] w_hash;
    logic        w_we;
    logic [AW-1:0] w_waddr;
    logic [lpht_pkg::WORD_W-1:0] w_wdata, w_rdata;

    // Active size, clamped to the supported range
    always_comb begin
        w_act = {1'b0, r_size_log2};
        if (w_act < lpht_pkg::SIZE_LOG2_MIN) begin
            w_act = lpht_pkg::SIZE_LOG2_MIN;
        end
        if (w_act > 5'(SLOTS_LOG2)) begin
            w_act = 5'(SLOTS_LOG2);
        end
        w_mask = {AW{1'b1}} >> (5'(SLOTS_LOG2) - w_act);
    end

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= lpht_pkg::SIZE_LOG2_RST;
            r_strict    <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == lpht_pkg::REG_SIZE_LOG2) begin
                r_size_log2 <= i_cfg_data;
            end else begin
                r_strict <= i_cfg_data[0];
            end
        end
    end

    // Clear sweep pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_ctl.clr_init) begin
            r_clr <= '0;
        end else if (i_ctl.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // Request, probe pointer and result registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_req) begin
            r_cmd    <= i_cmd;
            r_parent <= i_key_parent;
            r_name   <= i_key_name;
            r_value  <= i_entry_value;
            r_extra  <= i_entry_extra;
        end
        if (i_ctl.probe_init) begin
            r_pos <= w_hash[AW-1:0] & w_mask;
            r_cnt <= '0;
        end else if (i_ctl.probe_next) begin
            r_pos <= (r_pos + 1'b1) & w_mask;
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_ctl.res_load) begin
            r_res_status <= i_ctl.res_status;
            r_res_value  <= i_ctl.res_take_data ? w_rdata[63:32] : 32'h0;
            r_res_extra  <= i_ctl.res_take_data ? w_rdata[31:0] : 32'h0;
        end
    end

    lpht_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.hash_start),
        .i_key   ({r_name, r_parent}),
        .o_done  (w_hdone),
        .o_hash  (w_hash)
    );

    // Slot store write side: sweep writes an empty word
    assign w_we    = i_ctl.wr_ins | i_ctl.clr_step;
    assign w_waddr = i_ctl.clr_step ? r_clr : r_pos;
    assign w_wdata = i_ctl.clr_step ? '0 : {1'b1, r_parent, r_name, r_value, r_extra};

    lpht_ram #(
        .WIDTH (lpht_pkg::WORD_W),
        .DEPTH (1 << SLOTS_LOG2)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_ctl.rd_en),
        .i_raddr (r_pos),
        .o_rdata (w_rdata)
    );

    // Status back to the controller
    always_comb begin
        o_sts.is_insert  = (r_cmd == lpht_pkg::CMD_INSERT);
        o_sts.is_lookup  = (r_cmd == lpht_pkg::CMD_LOOKUP);
        o_sts.is_clear   = (r_cmd == lpht_pkg::CMD_CLEAR);
        o_sts.key_ok     = (r_parent != 32'h0) && (r_name != 32'h0);
        o_sts.val_ok     = (r_value != 32'h0);
        o_sts.hash_done  = w_hdone;
        o_sts.slot_empty = !w_rdata[lpht_pkg::WORD_W-1];
        o_sts.key_match  = (w_rdata[127:96] == r_parent) && (w_rdata[95:64] == r_name);
        o_sts.dup_ok     = !r_strict && (w_rdata[63:32] == r_value)
                           && (w_rdata[31:0] == r_extra);
        o_sts.probe_last = (r_cnt == w_mask);
        o_sts.clr_last   = &r_clr;
    end

    assign o_result_status = r_res_status;
    assign o_found_value   = r_res_value;
    assign o_found_extra   = r_res_extra;
endmodule

// ----- sv/lpht_ctrl.sv -----
// Controller: sequences decode, hashing, probing and clearing.
`timescale 1ns / 1ps
module lpht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  lpht_pkg::t_sts i_sts,
    output lpht_pkg::t_ctl o_ctl,
    output logic           o_result_valid
);
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_HASH,
        S_READ,
        S_CHECK,
        S_CLEAR
    } t_state;

    t_state r_state, n_state;
    logic   r_res_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ctl.res_status = lpht_pkg::ST_INVALID;
        case (r_state)
            S_INIT: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_ctl.load_req = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.is_clear) begin
                    o_ctl.clr_init = 1'b1;
                    n_state = S_CLEAR;
                end else if (i_sts.is_insert && i_sts.key_ok && i_sts.val_ok) begin
                    o_ctl.hash_start = 1'b1;
                    n_state = S_HASH;
                end else if (i_sts.is_lookup && i_sts.key_ok) begin
                    o_ctl.hash_start = 1'b1;
                    n_state = S_HASH;
                end else begin
                    o_ctl.res_load   = 1'b1;
                    o_ctl.res_status = i_sts.is_lookup ? lpht_pkg::ST_MISS
                                                       : lpht_pkg::ST_INVALID;
                    n_state = S_IDLE;
                end
            end
            S_HASH: begin
                if (i_sts.hash_done) begin
                    o_ctl.probe_init = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_ctl.rd_en = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_IDLE;
                if (i_sts.slot_empty) begin
                    o_ctl.res_load = 1'b1;
                    if (i_sts.is_insert) begin
                        o_ctl.wr_ins     = 1'b1;
                        o_ctl.res_status = lpht_pkg::ST_INSERTED;
                    end else begin
                        o_ctl.res_status = lpht_pkg::ST_MISS;
                    end
                end else if (i_sts.key_match) begin
                    o_ctl.res_load = 1'b1;
                    if (i_sts.is_insert) begin
                        o_ctl.res_status = i_sts.dup_ok ? lpht_pkg::ST_PRESENT
                                                        : lpht_pkg::ST_CONFLICT;
                    end else begin
                        o_ctl.res_status    = lpht_pkg::ST_HIT;
                        o_ctl.res_take_data = 1'b1;
                    end
                end else if (i_sts.probe_last) begin
                    o_ctl.res_load   = 1'b1;
                    o_ctl.res_status = i_sts.is_insert ? lpht_pkg::ST_FULL
                                                       : lpht_pkg::ST_MISS;
                end else begin
                    o_ctl.probe_next = 1'b1;
                    n_state = S_READ;
                end
            end
            S_CLEAR: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    o_ctl.res_load   = 1'b1;
                    o_ctl.res_status = lpht_pkg::ST_CLEARED;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= o_ctl.res_load;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_res_valid;

    // One result per request, never two in a row
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |=> !r_res_valid)
        else $error("result strobe on consecutive cycles");

    // Inserts only land on an empty slot
    a_ins_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.wr_ins |-> (i_sts.slot_empty && i_sts.is_insert && r_state == S_CHECK))
        else $error("insert write to an occupied slot");

    // Probing never goes past a full turn
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.probe_next |-> !i_sts.probe_last)
        else $error("probe beyond a full turn");

    // A request accepted leads to dispatch
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_DISPATCH))
        else $error("accepted request not dispatched");
endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the linear probe hash table.
`timescale 1ns / 1ps
module tb;
    localparam int           DEPTH_LOG2 = 10;
    localparam int           DEPTH      = 1 << DEPTH_LOG2;
    localparam logic [1:0]   CMD_UNUSED = 2'd3;
    localparam int           POOL_N     = 24;

    typedef struct packed {
        lpht_pkg::t_status st;
        logic [31:0]       val;
        logic [31:0]       ext;
    } t_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic                         i_cfg_we = 1'b0;
    logic                         i_cfg_idx = 1'b0;
    logic [lpht_pkg::CFG_W-1:0]   i_cfg_data = '0;
    logic [1:0]                   i_cmd = 2'd0;
    logic [31:0]                  i_key_parent = '0;
    logic [31:0]                  i_key_name = '0;
    logic [31:0]                  i_entry_value = '0;
    logic [31:0]                  i_entry_extra = '0;
    logic                         o_result_valid;
    logic [2:0]                   o_result_status;
    logic [31:0]                  o_found_value;
    logic [31:0]                  o_found_extra;

    linear_probe_hash_table #(.SLOTS_LOG2(DEPTH_LOG2)) dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Shadow of the table contents and registers
    bit          tbl_used   [DEPTH];
    logic [31:0] tbl_parent [DEPTH];
    logic [31:0] tbl_name   [DEPTH];
    logic [31:0] tbl_value  [DEPTH];
    logic [31:0] tbl_extra  [DEPTH];
    logic [3:0]  cur_size_log2 = lpht_pkg::SIZE_LOG2_RST;
    logic        cur_strict = 1'b0;

    t_result     expected_results[$];
    int          errors = 0;
    int          requests = 0;
    int          status_seen[8];
    int          idle_pct = 0;

    // Key pool so that repeats, hits and collisions are common
    logic [31:0] pool_parent[POOL_N];
    logic [31:0] pool_name[POOL_N];
    logic [31:0] pool_value[POOL_N];
    logic [31:0] pool_extra[POOL_N];

    function automatic logic [63:0] splitmix_final(logic [63:0] x);
        x = x ^ (x >> lpht_pkg::MIX_S0);
        x = x * lpht_pkg::MIX_C1;
        x = x ^ (x >> lpht_pkg::MIX_S1);
        x = x * lpht_pkg::MIX_C2;
        return x ^ (x >> lpht_pkg::MIX_S2);
    endfunction

    // Applies one request to the shadow table and returns its result
    function automatic t_result table_predict(logic [1:0] cmd, logic [31:0] p,
                                              logic [31:0] n, logic [31:0] v,
                                              logic [31:0] e);
        int      act;
        int      slots;
        int      mask;
        int      pos;
        t_result r;
        act = (cur_size_log2 < 4) ? 4 : (cur_size_log2 > DEPTH_LOG2) ? DEPTH_LOG2
              : int'(cur_size_log2);
        slots = 1 << act;
        mask = slots - 1;
        r = '{lpht_pkg::ST_INVALID, 32'd0, 32'd0};
        if (cmd == lpht_pkg::CMD_INSERT) begin
            if (p != 0 && n != 0 && v != 0) begin
                r.st = lpht_pkg::ST_FULL;
                pos = int'(splitmix_final({n, p}) & 64'(mask));
                for (int i = 0; i < slots; i++) begin
                    if (!tbl_used[pos]) begin
                        tbl_used[pos] = 1'b1;
                        tbl_parent[pos] = p;
                        tbl_name[pos] = n;
                        tbl_value[pos] = v;
                        tbl_extra[pos] = e;
                        r.st = lpht_pkg::ST_INSERTED;
                        break;
                    end
                    if (tbl_parent[pos] == p && tbl_name[pos] == n) begin
                        r.st = (!cur_strict && tbl_value[pos] == v && tbl_extra[pos] == e)
                               ? lpht_pkg::ST_PRESENT : lpht_pkg::ST_CONFLICT;
                        break;
                    end
                    pos = (pos + 1) & mask;
                end
            end
        end else if (cmd == lpht_pkg::CMD_LOOKUP) begin
            r.st = lpht_pkg::ST_MISS;
            if (p != 0 && n != 0) begin
                pos = int'(splitmix_final({n, p}) & 64'(mask));
                for (int i = 0; i < slots; i++) begin
                    if (!tbl_used[pos]) break;
                    if (tbl_parent[pos] == p && tbl_name[pos] == n) begin
                        r = '{lpht_pkg::ST_HIT, tbl_value[pos], tbl_extra[pos]};
                        break;
                    end
                    pos = (pos + 1) & mask;
                end
            end
        end else if (cmd == lpht_pkg::CMD_CLEAR) begin
            foreach (tbl_used[i]) tbl_used[i] = 1'b0;
            r.st = lpht_pkg::ST_CLEARED;
        end
        return r;
    endfunction

    // Drives one request and holds it until taken; optional gap afterwards
    task automatic send_request(logic [1:0] cmd, logic [31:0] p, logic [31:0] n,
                                logic [31:0] v, logic [31:0] e);
        start         <= 1'b1;
        i_cmd         <= cmd;
        i_key_parent  <= p;
        i_key_name    <= n;
        i_entry_value <= v;
        i_entry_extra <= e;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        expected_results.insert(expected_results.size(), table_predict(cmd, p, n, v, e));
        requests++;
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Drops start, waits for all results, then lets the block settle
    task automatic drain();
        start <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (expected_results.size() == 0) break;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [lpht_pkg::CFG_W-1:0] data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == lpht_pkg::REG_SIZE_LOG2) cur_size_log2 = data;
        else cur_strict = data[0];
    endtask

    task automatic fill_pool();
        for (int i = 0; i < POOL_N; i++) begin
            pool_parent[i] = $urandom() | 32'd1;
            pool_name[i]   = $urandom() | 32'd1;
            pool_value[i]  = $urandom() | 32'd1;
            pool_extra[i]  = $urandom();
        end
    endtask

    // Zero arguments, unused code, extremes, duplicates and clear
    task automatic test_basic_requests();
        send_request(lpht_pkg::CMD_INSERT, 32'd0, 32'd5, 32'd7, 32'd1);
        send_request(lpht_pkg::CMD_INSERT, 32'd5, 32'd0, 32'd7, 32'd1);
        send_request(lpht_pkg::CMD_INSERT, 32'd5, 32'd6, 32'd0, 32'd1);
        send_request(CMD_UNUSED, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_request(lpht_pkg::CMD_INSERT, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                     32'hffffffff);
        send_request(lpht_pkg::CMD_INSERT, 32'd1, 32'd1, 32'd1, 32'd0);
        send_request(lpht_pkg::CMD_LOOKUP, 32'hffffffff, 32'hffffffff, 32'd0, 32'd0);
        send_request(lpht_pkg::CMD_LOOKUP, 32'd0, 32'd1, 32'd0, 32'd0);
        send_request(lpht_pkg::CMD_LOOKUP, 32'd1, 32'd0, 32'd0, 32'd0);
        send_request(lpht_pkg::CMD_INSERT, 32'd1, 32'd1, 32'd1, 32'd0);
        send_request(lpht_pkg::CMD_INSERT, 32'd1, 32'd1, 32'd1, 32'd9);
        send_request(lpht_pkg::CMD_LOOKUP, 32'd1, 32'd1, 32'd0, 32'd0);
        send_request(lpht_pkg::CMD_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0);
        send_request(lpht_pkg::CMD_LOOKUP, 32'hffffffff, 32'hffffffff, 32'd0, 32'd0);
    endtask

    // Smallest table filled up, then an overfull insert and a full-turn miss
    task automatic test_full_table();
        write_reg(lpht_pkg::REG_SIZE_LOG2, 4'd0);
        write_reg(lpht_pkg::REG_STRICT, 4'd1);
        fill_pool();
        send_request(lpht_pkg::CMD_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0);
        for (int i = 0; i < 17; i++)
            send_request(lpht_pkg::CMD_INSERT, pool_parent[i], pool_name[i],
                         pool_value[i], pool_extra[i]);
        send_request(lpht_pkg::CMD_INSERT, pool_parent[0], pool_name[0], pool_value[0],
                     pool_extra[0]);
        send_request(lpht_pkg::CMD_LOOKUP, pool_parent[20], pool_name[20], 32'd0, 32'd0);
        send_request(lpht_pkg::CMD_LOOKUP, pool_parent[3], pool_name[3], 32'd0, 32'd0);
        // grow without clearing: old entries stay put
        write_reg(lpht_pkg::REG_SIZE_LOG2, 4'd5);
        for (int i = 0; i < 6; i++)
            send_request(lpht_pkg::CMD_LOOKUP, pool_parent[i], pool_name[i], 32'd0, 32'd0);
        write_reg(lpht_pkg::REG_SIZE_LOG2, 4'd15);
        write_reg(lpht_pkg::REG_STRICT, 4'd0);
        send_request(lpht_pkg::CMD_LOOKUP, pool_parent[1], pool_name[1], 32'd0, 32'd0);
    endtask

    // Random traffic over a small key pool, under one idling pattern
    task automatic test_random_phase(int pct, int count);
        int          r;
        int          k;
        logic [1:0]  cmd;
        logic [31:0] p, n, v, e;
        r = $urandom_range(0, 9);
        write_reg(lpht_pkg::REG_SIZE_LOG2, (r == 0) ? 4'($urandom_range(0, 3)) :
                  (r == 1) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(4, 6)));
        write_reg(lpht_pkg::REG_STRICT, 4'($urandom_range(0, 1)));
        fill_pool();
        idle_pct = pct;
        if ($urandom_range(0, 2) != 0)
            send_request(lpht_pkg::CMD_CLEAR, $urandom(), $urandom(), $urandom(),
                         $urandom());
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            cmd = (r < 46) ? lpht_pkg::CMD_INSERT : (r < 92) ? lpht_pkg::CMD_LOOKUP :
                  (r < 96) ? lpht_pkg::CMD_CLEAR : CMD_UNUSED;
            k = $urandom_range(0, POOL_N - 1);
            if ($urandom_range(0, 6) == 0) begin
                p = $urandom();
                n = $urandom();
            end else begin
                p = pool_parent[k];
                n = pool_name[k];
            end
            v = pool_value[k];
            e = pool_extra[k];
            if ($urandom_range(0, 4) == 0) v = v ^ $urandom();
            if ($urandom_range(0, 4) == 0) e = e ^ $urandom();
            r = $urandom_range(0, 99);
            if (r < 3) p = '0;
            else if (r < 6) n = '0;
            else if (r < 9) v = '0;
            send_request(cmd, p, n, v, e);
        end
        idle_pct = 0;
    endtask

    // Compare each result strobe with the oldest prediction
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_result_valid) begin
            status_seen[o_result_status]++;
            if (expected_results.size() == 0) begin
                $error("result with nothing outstanding, status %0d", o_result_status);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_result_status !== exp_r.st) begin
                    $error("result_status: expected %0d, got %0d", exp_r.st,
                           o_result_status);
                    errors++;
                end
                if (o_found_value !== exp_r.val) begin
                    $error("found_value: expected %h, got %h", exp_r.val, o_found_value);
                    errors++;
                end
                if (o_found_extra !== exp_r.ext) begin
                    $error("found_extra: expected %h, got %h", exp_r.ext, o_found_extra);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_requests();
        test_full_table();
        test_random_phase(0, 400);
        test_random_phase(66, 400);
        test_random_phase(0, 400);
        test_random_phase(36, 400);
        drain();
        $display("%0d requests: %0d inserted, %0d present, %0d conflict, %0d invalid,",
                 requests, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        $display("  %0d full, %0d hit, %0d miss, %0d cleared; %0d mismatches",
                 status_seen[4], status_seen[5], status_seen[6], status_seen[7], errors);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
sv/lpht_pkg.sv
sv/lpht_ram.sv
sv/lpht_hash.sv
sv/lpht_dp.sv
sv/lpht_ctrl.sv
sv/linear_probe_hash_table.sv
tb/tb.sv
